// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros shared by the scrambler rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// next-cycle implication, sampled on aclk, quiet while in reset
`define SKBS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("scrambler assertion failed");

// same-cycle implication, sampled on aclk, quiet while in reset
`define SKBS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("scrambler assertion failed");

`endif

// ===== hdl/skbs_pkg.sv =====
// ---------------------------------------------------------------------------
// skbs_pkg
// types and round tables of the seeded key bit scrambler
// ---------------------------------------------------------------------------
`default_nettype none

package skbs_pkg;

    localparam int unsigned KEY_W     = 32;
    localparam int unsigned TAB_DEPTH = 32;

    // one entry of the force table: 1-based bit position and the value forced
    typedef struct packed {
        logic [5:0] pos;
        logic       val;
    } skbs_force_t;

    // one entry of the swap table: two 1-based bit positions
    typedef struct packed {
        logic [5:0] pos_a;
        logic [5:0] pos_b;
    } skbs_swap_t;

    // what travels from one cell to the next
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] seed;
        logic [KEY_W-1:0] key;
    } skbs_stage_t;

    localparam skbs_force_t FORCE_TAB [TAB_DEPTH][2] = '{
        '{'{6'd11, 1'b0}, '{6'd31, 1'b1}}, '{'{6'd9,  1'b1}, '{6'd26, 1'b0}},
        '{'{6'd10, 1'b1}, '{6'd2,  1'b1}}, '{'{6'd4,  1'b1}, '{6'd7,  1'b0}},
        '{'{6'd14, 1'b0}, '{6'd29, 1'b1}}, '{'{6'd27, 1'b1}, '{6'd11, 1'b0}},
        '{'{6'd8,  1'b0}, '{6'd21, 1'b1}}, '{'{6'd12, 1'b1}, '{6'd8,  1'b0}},
        '{'{6'd6,  1'b1}, '{6'd22, 1'b0}}, '{'{6'd32, 1'b1}, '{6'd6,  1'b1}},
        '{'{6'd7,  1'b1}, '{6'd30, 1'b0}}, '{'{6'd25, 1'b0}, '{6'd18, 1'b0}},
        '{'{6'd15, 1'b1}, '{6'd28, 1'b0}}, '{'{6'd3,  1'b0}, '{6'd16, 1'b1}},
        '{'{6'd22, 1'b0}, '{6'd19, 1'b0}}, '{'{6'd18, 1'b1}, '{6'd17, 1'b0}},
        '{'{6'd2,  1'b1}, '{6'd32, 1'b0}}, '{'{6'd1,  1'b0}, '{6'd24, 1'b1}},
        '{'{6'd24, 1'b0}, '{6'd14, 1'b1}}, '{'{6'd28, 1'b0}, '{6'd10, 1'b0}},
        '{'{6'd26, 1'b0}, '{6'd9,  1'b1}}, '{'{6'd13, 1'b1}, '{6'd13, 1'b0}},
        '{'{6'd30, 1'b1}, '{6'd1,  1'b1}}, '{'{6'd17, 1'b0}, '{6'd20, 1'b1}},
        '{'{6'd19, 1'b1}, '{6'd12, 1'b0}}, '{'{6'd5,  1'b1}, '{6'd5,  1'b0}},
        '{'{6'd21, 1'b0}, '{6'd23, 1'b1}}, '{'{6'd23, 1'b1}, '{6'd25, 1'b0}},
        '{'{6'd31, 1'b0}, '{6'd15, 1'b1}}, '{'{6'd29, 1'b0}, '{6'd3,  1'b0}},
        '{'{6'd20, 1'b0}, '{6'd27, 1'b1}}, '{'{6'd16, 1'b1}, '{6'd4,  1'b0}}
    };

    localparam skbs_swap_t SWAP_TAB [TAB_DEPTH][2] = '{
        '{'{6'd23, 6'd1 }, '{6'd20, 6'd32}}, '{'{6'd7,  6'd8 }, '{6'd6,  6'd5 }},
        '{'{6'd8,  6'd29}, '{6'd19, 6'd22}}, '{'{6'd29, 6'd11}, '{6'd24, 6'd27}},
        '{'{6'd9,  6'd10}, '{6'd18, 6'd2 }}, '{'{6'd25, 6'd26}, '{6'd17, 6'd26}},
        '{'{6'd4,  6'd17}, '{6'd9,  6'd23}}, '{'{6'd6,  6'd19}, '{6'd3,  6'd29}},
        '{'{6'd2,  6'd24}, '{6'd2,  6'd18}}, '{'{6'd16, 6'd30}, '{6'd10, 6'd11}},
        '{'{6'd27, 6'd28}, '{6'd13, 6'd20}}, '{'{6'd18, 6'd32}, '{6'd4,  6'd12}},
        '{'{6'd15, 6'd20}, '{6'd15, 6'd16}}, '{'{6'd3,  6'd22}, '{6'd14, 6'd21}},
        '{'{6'd5,  6'd6 }, '{6'd1,  6'd30}}, '{'{6'd13, 6'd25}, '{6'd7,  6'd31}},
        '{'{6'd14, 6'd31}, '{6'd26, 6'd3 }}, '{'{6'd21, 6'd12}, '{6'd11, 6'd17}},
        '{'{6'd31, 6'd2 }, '{6'd12, 6'd24}}, '{'{6'd11, 6'd23}, '{6'd5,  6'd28}},
        '{'{6'd32, 6'd3 }, '{6'd8,  6'd14}}, '{'{6'd10, 6'd13}, '{6'd25, 6'd4 }},
        '{'{6'd12, 6'd14}, '{6'd22, 6'd6 }}, '{'{6'd19, 6'd21}, '{6'd27, 6'd19}},
        '{'{6'd20, 6'd4 }, '{6'd23, 6'd25}}, '{'{6'd17, 6'd15}, '{6'd16, 6'd13}},
        '{'{6'd22, 6'd5 }, '{6'd21, 6'd7 }}, '{'{6'd24, 6'd7 }, '{6'd28, 6'd8 }},
        '{'{6'd26, 6'd27}, '{6'd32, 6'd1 }}, '{'{6'd28, 6'd9 }, '{6'd31, 6'd10}},
        '{'{6'd1,  6'd18}, '{6'd30, 6'd15}}, '{'{6'd30, 6'd16}, '{6'd29, 6'd9 }}
    };

    // 1-based table position to key bit index, wrapping modulo 32
    function automatic logic [4:0] pos_to_idx(input logic [5:0] pos);
        logic [5:0] diff;
        diff = pos - 6'd1;
        return diff[4:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/skbs_cell.sv =====
// ---------------------------------------------------------------------------
// skbs_cell
// one scrambler round: conditional bit force then a two-bit swap, registered
// ---------------------------------------------------------------------------
`default_nettype none

module skbs_cell
    import skbs_pkg::*;
#(
    parameter int unsigned ROUND = 0
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        advance,
    input  wire skbs_stage_t stage_in,
    output skbs_stage_t      stage_out
);

    localparam logic [4:0] RIDX = ROUND[4:0];

    logic             valid_reg;
    logic             valid_next;
    logic [KEY_W-1:0] seed_reg;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;

    logic             row;
    skbs_force_t      force_ent;
    skbs_swap_t       swap_ent;
    logic [4:0]       force_idx;
    logic [4:0]       idx_a;
    logic [4:0]       idx_b;
    logic [KEY_W-1:0] key_forced;

    always_comb begin
        row       = stage_in.seed[RIDX];
        force_ent = FORCE_TAB[RIDX][row];
        swap_ent  = SWAP_TAB[RIDX][row];
        force_idx = pos_to_idx(force_ent.pos);
        idx_a     = pos_to_idx(swap_ent.pos_a);
        idx_b     = pos_to_idx(swap_ent.pos_b);

        key_forced = stage_in.key;
        if (stage_in.key[2:0] == 3'b000) begin
            key_forced[force_idx] = force_ent.val;
        end

        // equal positions leave the key as it is
        key_next        = key_forced;
        key_next[idx_a] = key_forced[idx_b];
        key_next[idx_b] = key_forced[idx_a];

        valid_next = advance ? stage_in.valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            seed_reg <= stage_in.seed;
            key_reg  <= key_next;
        end
    end

    assign stage_out.valid = valid_reg;
    assign stage_out.seed  = seed_reg;
    assign stage_out.key   = key_reg;

endmodule

`default_nettype wire

// ===== hdl/seeded_key_bit_scrambler_top.sv =====
// ---------------------------------------------------------------------------
// seeded_key_bit_scrambler_top
// seeded key bit scrambler, one round per cell
// ---------------------------------------------------------------------------
// A row of ROUNDS cells, one per round, each registering its result. A key
// passes through the cell registers in turn from input transfer to output
// valid. The chain accepts one new key every cycle unless halted; the whole
// row halts only while the last cell holds a result that m_tready has not yet taken.
`default_nettype none

`include "assert_macros.svh"

module seeded_key_bit_scrambler_top
    import skbs_pkg::*;
#(
    parameter int unsigned ROUNDS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // seed [31:0], key_in [63:32]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // key_out [31:0]
);

    skbs_stage_t stage [ROUNDS+1];
    logic        advance;

    // the row moves whenever the last cell is empty or being drained
    assign advance  = !stage[ROUNDS].valid || m_tready;
    assign s_tready = advance;

    assign stage[0].valid = s_tvalid;
    assign stage[0].seed  = s_tdata[31:0];
    assign stage[0].key   = s_tdata[63:32];

    for (genvar r = 0; r < ROUNDS; r++) begin : g_round
        skbs_cell #(
            .ROUND (r)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .stage_in  (stage[r]),
            .stage_out (stage[r+1])
        );
    end

    assign m_tvalid = stage[ROUNDS].valid;
    assign m_tdata  = stage[ROUNDS].key;

    // an accepted transfer lands in the first cell
    `SKBS_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, stage[1].valid)
    // a stalled row keeps its first cell untouched
    `SKBS_ASSERT_NEXT(a_stall_holds, !s_tready, $stable(stage[1]))
    // the row only halts behind a waiting result
    `SKBS_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid && !m_tready)

endmodule

`default_nettype wire
